@@ rtl/core/dq_pkg.sv @@
// Shared constants and types for the double-ended queue.
package dq_pkg;

    localparam int DEPTH = 64;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

@@ rtl/core/dq_ram.sv @@
// Generic simple dual-port RAM with registered read.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/double_ended_queue.sv @@
// Double-ended queue top level: ring store in RAM with front index and count.
// A result passes through stage 1 (the RAM read) and then the output register
// after its transaction is accepted, and can be taken from there.
// Throughput: one transaction per cycle unless o_in_stall is high; a successful push
// uses the RAM write port once, and a successful pop the registered read port.
// Reset: synchronous, active low; clears front index, count and valid flags.
// RAM contents are not cleared; only written entries are ever read.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic signed [31:0] i_push_value,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [31:0] o_pop_value,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;   // front + count stays below 2*DEPTH

    // Queue state
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // Stage 1: waits for the RAM read data
    logic             r_s1_valid;
    dq_pkg::t_status  r_s1_status, n_s1_status;
    logic             r_s1_pop, n_s1_pop;

    // Output register
    logic             r_out_valid;
    dq_pkg::t_status  r_out_status;
    logic [31:0]      r_out_value;

    // RAM port signals
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_rdata;

    logic          accept, s1_adv, is_full, is_empty;
    logic [AW-1:0] front_dec, front_inc, back_push, back_pop;
    logic [SW-1:0] sum_push, sum_pop;
    dq_pkg::t_cmd  cmd;

    // Stage 1 moves on whenever the output register is free or being drained.
    // A held stage 1 keeps the RAM read data since no new read is issued.
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign cmd      = dq_pkg::t_cmd'(i_command);
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Ring index arithmetic, modulo DEPTH with a single compare and subtract
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign sum_push  = SW'(r_front) + SW'(r_count);
    assign sum_pop   = sum_push - SW'(1);
    assign back_push = (sum_push >= SW'(DEPTH)) ? AW'(sum_push - SW'(DEPTH))
                                                : AW'(sum_push);
    assign back_pop  = (sum_pop >= SW'(DEPTH)) ? AW'(sum_pop - SW'(DEPTH))
                                               : AW'(sum_pop);

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_s1_status = dq_pkg::ST_OK;
        n_s1_pop    = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = front_dec;
        ram_raddr   = r_front;
        unique case (cmd)
            dq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    n_s1_status = dq_pkg::ST_FULL;
                end else begin
                    ram_we    = accept;
                    ram_waddr = front_dec;
                    n_front   = front_dec;
                    n_count   = r_count + CW'(1);
                end
            end
            dq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    n_s1_status = dq_pkg::ST_FULL;
                end else begin
                    ram_we    = accept;
                    ram_waddr = back_push;
                    n_count   = r_count + CW'(1);
                end
            end
            dq_pkg::CMD_POP_FRONT: begin
                if (is_empty) begin
                    n_s1_status = dq_pkg::ST_EMPTY;
                end else begin
                    ram_re    = accept;
                    ram_raddr = r_front;
                    n_s1_pop  = 1'b1;
                    n_front   = front_inc;
                    n_count   = r_count - CW'(1);
                end
            end
            dq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    n_s1_status = dq_pkg::ST_EMPTY;
                end else begin
                    ram_re    = accept;
                    ram_raddr = back_pop;
                    n_s1_pop  = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_status <= n_s1_status;
            r_s1_pop    <= n_s1_pop;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_status <= r_s1_status;
            r_out_value  <= r_s1_pop ? ram_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_out_value;
    assign o_status    = r_out_status;

endmodule
